>>> rtl/core/psrl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psrl_pkg: shared types and constants for the per-sender rate limiter
// Request and result payloads, configuration codes and reset values.
// ----------------------------------------------------------------------------
package psrl_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int ID_BYTES_DEF      = 8;

    localparam int ID_W     = 64;
    localparam int TIME_W   = 48;
    localparam int COUNT_W  = 16;
    localparam int WINDOW_W = 32;
    localparam int MAX_W    = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_WINDOW = 1'd1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd60000000;
    localparam logic [MAX_W-1:0]    MAX_RESET    = 16'd20;

    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 16'hFFFF;

    typedef struct packed {
        logic [ID_W-1:0]   sender_id;
        logic [TIME_W-1:0] now_us;
    } req_t;

    typedef struct packed {
        logic limited;
        logic new_entry;
        logic evicted;
    } rsp_t;

    typedef struct packed {
        logic [WINDOW_W-1:0] window_length_us;
        logic [MAX_W-1:0]    max_per_window;
    } cfg_t;

endpackage
`default_nettype wire

>>> rtl/core/psrl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psrl_ram: generic single-write, single-read synchronous RAM
// One write port, one read port with the read data registered.
// ----------------------------------------------------------------------------
module psrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/core/psrl_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psrl_engine: lookup, window update and allocation sequencer
// Scans the sender table one entry a cycle, then updates or allocates.
// ----------------------------------------------------------------------------
module psrl_engine #(
    parameter int TABLE_ENTRIES = psrl_pkg::TABLE_ENTRIES_DEF,
    parameter int ID_BYTES      = psrl_pkg::ID_BYTES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire psrl_pkg::cfg_t       cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire psrl_pkg::req_t       in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output psrl_pkg::rsp_t            out_data
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int ID_BITS = 8 * ID_BYTES;
    localparam int ENTRY_W = ID_BITS + psrl_pkg::TIME_W + psrl_pkg::COUNT_W;
    localparam int CNT_LO  = 0;
    localparam int CNT_HI  = psrl_pkg::COUNT_W - 1;
    localparam int ST_LO   = psrl_pkg::COUNT_W;
    localparam int ST_HI   = psrl_pkg::COUNT_W + psrl_pkg::TIME_W - 1;
    localparam int ID_LO   = psrl_pkg::COUNT_W + psrl_pkg::TIME_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_WRITE
    } state_t;

    state_t                        state_reg;
    psrl_pkg::req_t                req_reg;
    logic [TABLE_ENTRIES-1:0]      used_reg;
    logic [IDX_W-1:0]              rd_idx_reg;
    logic                          chk_valid_reg;
    logic [IDX_W-1:0]              chk_idx_reg;
    logic                          hit_reg;
    logic [IDX_W-1:0]              hit_idx_reg;
    logic [psrl_pkg::TIME_W-1:0]   hit_start_reg;
    logic [psrl_pkg::COUNT_W-1:0]  hit_count_reg;
    logic                          restart_reg;
    logic                          free_found_reg;
    logic [IDX_W-1:0]              free_idx_reg;
    logic [IDX_W-1:0]              old_idx_reg;
    logic [psrl_pkg::TIME_W-1:0]   old_start_reg;
    logic                          out_valid_reg;
    psrl_pkg::rsp_t                out_data_reg;

    logic                          ram_we;
    logic [IDX_W-1:0]              ram_waddr;
    logic [ENTRY_W-1:0]            ram_wdata;
    logic [ENTRY_W-1:0]            ram_rdata;

    logic [ID_BITS-1:0]            req_id;
    logic [ID_BITS-1:0]            rd_id;
    logic [psrl_pkg::TIME_W-1:0]   rd_start;
    logic [psrl_pkg::COUNT_W-1:0]  rd_count;
    logic                          rd_used;
    logic                          rd_hit;
    logic                          rd_older;
    logic [psrl_pkg::TIME_W-1:0]   elapsed;
    logic [psrl_pkg::COUNT_W-1:0]  cnt_base;
    logic [psrl_pkg::COUNT_W-1:0]  cnt_new;
    logic [psrl_pkg::TIME_W-1:0]   start_new;
    logic [IDX_W-1:0]              miss_idx;
    logic                          out_free;

    psrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign req_id   = req_reg.sender_id[ID_BITS-1:0];
    assign rd_id    = ram_rdata[ENTRY_W-1:ID_LO];
    assign rd_start = ram_rdata[ST_HI:ST_LO];
    assign rd_count = ram_rdata[CNT_HI:CNT_LO];
    assign rd_used  = used_reg[chk_idx_reg];
    assign rd_hit   = rd_used && (rd_id == req_id);
    assign rd_older = (chk_idx_reg == '0) || (rd_start < old_start_reg);

    assign elapsed  = req_reg.now_us - hit_start_reg;

    // restart the window first, then count this request, saturating
    assign cnt_base  = restart_reg ? '0 : hit_count_reg;
    assign cnt_new   = (cnt_base == psrl_pkg::COUNT_MAX) ? cnt_base
                                                         : cnt_base + 1'b1;
    assign start_new = restart_reg ? req_reg.now_us : hit_start_reg;
    assign miss_idx  = free_found_reg ? free_idx_reg : old_idx_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        ram_we    = (state_reg == S_WRITE) && out_free;
        ram_waddr = hit_reg ? hit_idx_reg : miss_idx;
        if (hit_reg)
        begin
            ram_wdata = {req_id, start_new, cnt_new};
        end
        else
        begin
            ram_wdata = {req_id, req_reg.now_us, psrl_pkg::COUNT_W'(1)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            chk_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // drop the taken result unless a new one is loaded this cycle
            if (out_valid_reg && out_ready && !ram_we)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg        <= in_data;
                        rd_idx_reg     <= '0;
                        chk_valid_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // issue the next read while checking the previous one
                    if (rd_idx_reg != LAST_IDX)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    chk_valid_reg <= 1'b1;
                    chk_idx_reg   <= rd_idx_reg;
                    if (chk_valid_reg)
                    begin
                        if (!rd_used && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= chk_idx_reg;
                        end
                        if (rd_older)
                        begin
                            old_idx_reg   <= chk_idx_reg;
                            old_start_reg <= rd_start;
                        end
                        if (rd_hit)
                        begin
                            hit_reg       <= 1'b1;
                            hit_idx_reg   <= chk_idx_reg;
                            hit_start_reg <= rd_start;
                            hit_count_reg <= rd_count;
                            state_reg     <= S_CALC;
                        end
                        else if (chk_idx_reg == LAST_IDX)
                        begin
                            hit_reg       <= 1'b0;
                            state_reg     <= S_WRITE;
                        end
                    end
                end
                S_CALC:
                begin
                    restart_reg <= (elapsed >
                                    psrl_pkg::TIME_W'(cfg.window_length_us));
                    state_reg   <= S_WRITE;
                end
                S_WRITE:
                begin
                    // hold until the result register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (hit_reg)
                        begin
                            out_data_reg.limited   <= (cnt_new > cfg.max_per_window);
                            out_data_reg.new_entry <= 1'b0;
                            out_data_reg.evicted   <= 1'b0;
                        end
                        else
                        begin
                            used_reg[miss_idx]     <= 1'b1;
                            out_data_reg.limited   <= 1'b0;
                            out_data_reg.new_entry <= 1'b1;
                            out_data_reg.evicted   <= !free_found_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_rise_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_WRITE))
        else $error("result raised outside the write step");

    a_write_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (state_reg == S_IDLE) && out_valid_reg)
        else $error("table write not followed by a result");

    a_new_not_limited: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.new_entry || out_data_reg.evicted)
            |-> !out_data_reg.limited && out_data_reg.new_entry)
        else $error("allocation result flags inconsistent");

    a_used_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (($past(used_reg) & ~used_reg) == '0))
        else $error("used mark cleared outside reset");
`endif

endmodule
`default_nettype wire

>>> rtl/core/per_sender_rate_limiter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// per_sender_rate_limiter: fixed-window packet rate limiter per sender
// Holds configuration and wraps the table sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_ready/in_data) carries a sender identifier and
//   a 48-bit microsecond arrival time. Result channel (out_valid/out_ready/
//   out_data) returns limited, new_entry and evicted, one result per request.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write it
//   only while no request is in flight. Unknown indexes are dropped.
//   A request scans the sender table one entry per cycle through the table
//   memory's single read port. A hit stops the scan and checks the window
//   before the table write; a miss scans every entry, then allocates.
//   The result appears in the output register in the same cycle as in_ready
//   rises.
//   When the receiver stalls, the block accepts one further request and holds
//   that request's table write until the pending result is taken.
//   Reset clears every used mark and loads the default window (60 s) and
//   allowance (20); table contents need no clearing pass.
// ----------------------------------------------------------------------------
module per_sender_rate_limiter #(
    parameter int TABLE_ENTRIES = psrl_pkg::TABLE_ENTRIES_DEF,
    parameter int ID_BYTES      = psrl_pkg::ID_BYTES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire psrl_pkg::req_t                     in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output psrl_pkg::rsp_t                          out_data,
    input  wire logic                               cfg_we,
    input  wire logic [psrl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [psrl_pkg::CFG_W-1:0]         cfg_data
);

    psrl_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length_us <= psrl_pkg::WINDOW_RESET;
            cfg_reg.max_per_window   <= psrl_pkg::MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                psrl_pkg::REG_WINDOW_LENGTH:
                begin
                    cfg_reg.window_length_us <= cfg_data;
                end
                psrl_pkg::REG_MAX_PER_WINDOW:
                begin
                    cfg_reg.max_per_window <= cfg_data[psrl_pkg::MAX_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    psrl_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ID_BYTES      (ID_BYTES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

>>> verif/rate_limit_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rate_limit_checker: verdict predictor and comparator for the rate limiter
// Mirrors configuration writes and the sender table, works out the verdict of
// each accepted request and compares it, field by field, with the block's
// results in order of arrival.
// ----------------------------------------------------------------------------
module rate_limit_checker #(
    parameter int ENTRIES  = psrl_pkg::TABLE_ENTRIES_DEF,
    parameter int ID_BYTES = psrl_pkg::ID_BYTES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire psrl_pkg::req_t                 in_data,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire psrl_pkg::rsp_t                 out_data,
    input  wire logic                           cfg_we,
    input  wire logic [psrl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [psrl_pkg::CFG_W-1:0]     cfg_data,
    output int                                  mismatches,
    output int                                  outstanding
);

    localparam logic [psrl_pkg::ID_W-1:0] ID_MASK =
        {psrl_pkg::ID_W{1'b1}} >> (psrl_pkg::ID_W - 8 * ID_BYTES);

    logic [psrl_pkg::WINDOW_W-1:0] window_len;
    logic [psrl_pkg::MAX_W-1:0]    allowance;
    logic                          entry_live  [ENTRIES];
    logic [psrl_pkg::ID_W-1:0]     entry_owner [ENTRIES];
    logic [psrl_pkg::TIME_W-1:0]   entry_start [ENTRIES];
    logic [psrl_pkg::COUNT_W-1:0]  entry_hits  [ENTRIES];
    psrl_pkg::rsp_t                expected_verdicts [$];
    psrl_pkg::rsp_t                want;

    function automatic psrl_pkg::rsp_t predict_verdict(input psrl_pkg::req_t req);
        psrl_pkg::rsp_t              verdict;
        logic [psrl_pkg::ID_W-1:0]   id;
        logic [psrl_pkg::TIME_W-1:0] elapsed;
        int                          hit;
        int                          spare;
        int                          victim;
        id      = req.sender_id & ID_MASK;
        hit     = -1;
        spare   = -1;
        verdict = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && entry_live[i] && entry_owner[i] == id)
                hit = i;
            if (spare < 0 && !entry_live[i])
                spare = i;
        end
        if (hit >= 0)
        begin
            // elapsed time wraps modulo 2^48, so a step back reads as very long
            elapsed = req.now_us - entry_start[hit];
            if (elapsed > window_len)
            begin
                entry_start[hit] = req.now_us;
                entry_hits[hit]  = '0;
            end
            if (entry_hits[hit] != psrl_pkg::COUNT_MAX)
                entry_hits[hit] = entry_hits[hit] + 1'b1;
            verdict.limited = (entry_hits[hit] > allowance);
        end
        else
        begin
            victim = spare;
            if (spare < 0)
            begin
                // table full: replace the oldest window start, lowest index on ties
                victim = 0;
                for (int i = 1; i < ENTRIES; i++)
                begin
                    if (entry_start[i] < entry_start[victim])
                        victim = i;
                end
                verdict.evicted = 1'b1;
            end
            entry_live[victim]  = 1'b1;
            entry_owner[victim] = id;
            entry_start[victim] = req.now_us;
            entry_hits[victim]  = psrl_pkg::COUNT_W'(1);
            verdict.new_entry   = 1'b1;
        end
        return verdict;
    endfunction

    task automatic check_field(input string field, input logic expected_bit,
                               input logic actual_bit);
        if (actual_bit !== expected_bit)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %b actual %b",
                     $time, field, expected_bit, actual_bit);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len = psrl_pkg::WINDOW_RESET;
            allowance  = psrl_pkg::MAX_RESET;
            for (int i = 0; i < ENTRIES; i++)
                entry_live[i] = 1'b0;
            expected_verdicts.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with no request waiting, expected none actual %b",
                             $time, out_data);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    check_field("limited", want.limited, out_data.limited);
                    check_field("new_entry", want.new_entry, out_data.new_entry);
                    check_field("evicted", want.evicted, out_data.evicted);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    psrl_pkg::REG_WINDOW_LENGTH:
                        window_len = cfg_data[psrl_pkg::WINDOW_W-1:0];
                    psrl_pkg::REG_MAX_PER_WINDOW:
                        allowance  = cfg_data[psrl_pkg::MAX_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_verdicts.push_back(predict_verdict(in_data));
            outstanding = expected_verdicts.size();
        end
    end

endmodule
`default_nettype wire

>>> verif/per_sender_rate_limiter_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// per_sender_rate_limiter_tb: top-level testbench for the rate limiter
// Drives directed arrivals and then phases of random sender traffic under a
// range of window and allowance settings, with bursty requests and a
// stalling receiver. Prediction and checking sit in rate_limit_checker.
// ----------------------------------------------------------------------------
module per_sender_rate_limiter_tb;

    localparam int ENTRIES       = psrl_pkg::TABLE_ENTRIES_DEF;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = ENTRIES + 8;
    localparam int POOL_MAX      = 64;

    typedef enum {RX_OPEN, RX_RANDOM, RX_CHOKED} rx_mode_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    psrl_pkg::req_t                 in_data;
    logic                           out_valid;
    logic                           out_ready;
    psrl_pkg::rsp_t                 out_data;
    logic                           cfg_we;
    logic [psrl_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [psrl_pkg::CFG_W-1:0]     cfg_data;

    int                             mismatches;
    int                             outstanding;
    int                             quiet_cycles;
    int                             burst_left;
    logic [psrl_pkg::ID_W-1:0]      senders [POOL_MAX];
    logic [psrl_pkg::TIME_W-1:0]    clock_us;
    rx_mode_t                       rx_mode;
    int                             rx_mode_left = 0;
    int                             rx_stall_left = 0;

    per_sender_rate_limiter #(
        .TABLE_ENTRIES(ENTRIES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    rate_limit_checker #(
        .ENTRIES(ENTRIES)
    ) verdict_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: open, coin-toss or choked stretches of random length
    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(16, 256);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
            default:
            begin
                if (rx_stall_left == 0)
                begin
                    out_ready     <= 1'b1;
                    rx_stall_left = $urandom_range(4, 24);
                end
                else
                begin
                    out_ready <= 1'b0;
                    rx_stall_left--;
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("per_sender_rate_limiter_tb failed");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_arrival(input logic [psrl_pkg::ID_W-1:0] id,
                                input logic [psrl_pkg::TIME_W-1:0] at_us);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 40 : 6))
                @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {id, at_us};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic wait_until_idle();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (outstanding != 0)
            @(negedge clk);
        // settle before reconfiguring; the last table write landed with its result
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic set_limits(input logic [psrl_pkg::WINDOW_W-1:0] window,
                              input logic [psrl_pkg::MAX_W-1:0] allowance);
        cfg_we    <= 1'b1;
        cfg_index <= psrl_pkg::REG_WINDOW_LENGTH;
        cfg_data  <= window;
        @(negedge clk);
        cfg_index <= psrl_pkg::REG_MAX_PER_WINDOW;
        // upper bits are junk and must be dropped
        cfg_data  <= {16'($urandom()), allowance};
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [psrl_pkg::WINDOW_W-1:0] window,
                             input logic [psrl_pkg::MAX_W-1:0] allowance,
                             input int pool, input int count);
        int unsigned               tick;
        int                        roll;
        logic [psrl_pkg::ID_W-1:0] id;
        wait_until_idle();
        set_limits(window, allowance);
        tick = (window >> 3) + 1;
        // some senders differ from the first in a single bit
        for (int i = 0; i < pool; i++)
        begin
            if (i > 0 && $urandom_range(0, 3) == 0)
                senders[i] = senders[0] ^ (64'd1 << $urandom_range(0, 63));
            else
                senders[i] = {$urandom(), $urandom()};
        end
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                ;
            else if (roll < 80)
                clock_us = clock_us + $urandom_range(1, tick);
            else if (roll < 95)
                clock_us = clock_us + window + $urandom_range(0, 2) - 1;
            else
                clock_us = {16'($urandom()), 32'($urandom())};
            if ($urandom_range(0, 99) < 90)
                id = senders[$urandom_range(0, pool - 1)];
            else
                id = {$urandom(), $urandom()};
            send_arrival(id, clock_us);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        burst_left = 0;
        clock_us   = '0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default limits: extremes, wrap-around and time going backwards
        send_arrival(64'd0, 48'd0);
        send_arrival(64'd0, 48'd0);
        send_arrival({psrl_pkg::ID_W{1'b1}}, {psrl_pkg::TIME_W{1'b1}});
        send_arrival({psrl_pkg::ID_W{1'b1}}, 48'd0);
        send_arrival(64'h8000_0000_0000_0000, 48'd1);
        send_arrival(64'd1, 48'd2);
        send_arrival(64'd0, 48'h8000_0000_0000);
        send_arrival(64'd0, 48'd5);

        // short window, allowance of two: limit, window edge, restart
        wait_until_idle();
        set_limits(32'd10, 16'd2);
        send_arrival(64'hA5A5_5A5A_A5A5_5A5A, 48'd100);
        send_arrival(64'hA5A5_5A5A_A5A5_5A5A, 48'd100);
        send_arrival(64'hA5A5_5A5A_A5A5_5A5A, 48'd105);
        send_arrival(64'hA5A5_5A5A_A5A5_5A5A, 48'd110);
        send_arrival(64'hA5A5_5A5A_A5A5_5A5A, 48'd111);
        send_arrival(64'h5A5A_A5A5_5A5A_A5A5, 48'd111);
        clock_us = 48'd200;

        run_phase(32'd0, 16'd0, 6, 160);
        run_phase(32'd1, 16'd1, 10, 160);
        run_phase(32'd7, 16'd3, 36, 180);
        run_phase(32'd1000, 16'd5, 20, 160);
        run_phase(32'hFFFF_FFFF, 16'hFFFF, 12, 160);
        run_phase(32'hFFFF_FFFF, 16'd65534, 34, 160);
        run_phase(32'd100, 16'd2, 48, 180);
        run_phase(psrl_pkg::WINDOW_RESET, psrl_pkg::MAX_RESET, 40, 160);
        repeat (4)
            run_phase($urandom_range(1, 50000), psrl_pkg::MAX_W'($urandom_range(1, 8)),
                      $urandom_range(2, 48), 120);

        wait_until_idle();
        if (mismatches == 0)
            $display("per_sender_rate_limiter_tb passed");
        else
            $display("per_sender_rate_limiter_tb failed");
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
rtl/core/psrl_pkg.sv
rtl/core/psrl_ram.sv
rtl/core/psrl_engine.sv
rtl/core/per_sender_rate_limiter.sv
verif/rate_limit_checker.sv
verif/per_sender_rate_limiter_tb.sv
